// ===== design/shld_pkg.sv =====
// shared types and constants of the sample history logger download core
package shld_pkg;

    localparam int unsigned IN_DATA_W  = 120;
    localparam int unsigned OUT_DATA_W = 208;
    localparam int unsigned SAMPLE_W   = 48;
    localparam int unsigned OUT_CNT_W  = 13;

    localparam logic [1:0] MODE_TICK   = 2'd0;
    localparam logic [1:0] MODE_SUB    = 2'd1;
    localparam logic [1:0] MODE_UNSUB  = 2'd2;

    localparam logic [1:0] KIND_NONE   = 2'd0;
    localparam logic [1:0] KIND_HEADER = 2'd1;
    localparam logic [1:0] KIND_DATA   = 2'd2;

    localparam logic [31:0] DEFAULT_INTERVAL_MS = 32'd600000;

    typedef enum logic [2:0] {
        PH_IDLE   = 3'b001,
        PH_HEADER = 3'b010,
        PH_DATA   = 3'b100
    } phase_t;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_EXEC = 7'b0000010,
        ST_ADDR = 7'b0000100,
        ST_RD0  = 7'b0001000,
        ST_RD1  = 7'b0010000,
        ST_RD2  = 7'b0100000,
        ST_DONE = 7'b1000000
    } state_t;

    typedef struct packed {
        logic                 sample_logged;
        logic [OUT_CNT_W-1:0] stored_count;
        logic                 last_packet;
        logic [1:0]           samples_in_packet;
        logic [63:0]          second_sample;
        logic [63:0]          first_sample;
        logic [OUT_CNT_W-1:0] download_count;
        logic [31:0]          age_ms;
        logic [15:0]          sequence_res;
        logic [1:0]           packet_kind;
    } result_t;

endpackage

// ===== design/shld_ring.sv =====
// single-port history ring memory with registered read data
module shld_ring #(
    parameter int unsigned DEPTH = 4096,
    parameter int unsigned WIDTH = 48
) (
    input  logic                     aclk,
    input  logic                     en,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            if (we) begin
                mem[addr] <= wdata;
            end else begin
                rdata_reg <= mem[addr];
            end
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/sample_history_logger_download_core.sv =====
// top level of the sample history logger with ring buffer and packetised download
//
// Each accepted beat is handled on its own and gives exactly one result beat. A tick
// that sends no packet, or a header, or a subscribe/unsubscribe beat, passes through the
// EXEC and DONE states to the output register, and the next beat can be accepted once the
// block is back in IDLE. A tick that sends a data packet passes through EXEC, ADDR, RD0,
// RD1, RD2 and DONE: the single-port history ring first takes any new sample's write in
// EXEC, ADDR forms the read address, and then the two sample reads are issued one after
// the other in RD0 and RD1, each with registered read data.
// The result sits in an output register, so the next beat is accepted while a result
// still waits to be taken; a second finished result holds the block in its last step
// until the first is taken. The ring is not cleared at reset; only held entries are read.
module sample_history_logger_download_core #(
    parameter int unsigned DEPTH         = 4096,
    parameter int unsigned PACKET_GAP_MS = 4
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // cfg_data: sample_interval_ms
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [31:0]                     cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: now_ms, reading_valid, temperature_raw, humidity_raw, co2_ppm,
    // requested_samples, zero fill
    input  logic [shld_pkg::IN_DATA_W-1:0]  s_tdata,
    // s_tuser: mode
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: sequence_res, age_ms, download_count, first_sample, second_sample,
    // samples_in_packet, stored_count, sample_logged, zero fill
    output logic [shld_pkg::OUT_DATA_W-1:0] m_tdata,
    // m_tuser: packet_kind
    output logic [1:0]                      m_tuser,
    // m_tlast: last_packet
    output logic                            m_tlast
);

    localparam int unsigned PW = $clog2(DEPTH);
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned OW = shld_pkg::OUT_CNT_W;

    shld_pkg::state_t state_reg, state_next;
    shld_pkg::phase_t phase_reg, phase_next;

    logic [1:0]  mode_reg;
    logic [31:0] now_reg;
    logic        rvalid_reg;
    logic [47:0] smp_in_reg;
    logic [31:0] req_reg;

    logic [31:0] interval_reg, interval_next;
    logic [32:0] interval2_reg, interval2_next;
    logic [PW-1:0] wp_reg, wp_next;
    logic [PW-1:0] oldest_reg, oldest_next;
    logic [CW-1:0] held_reg, held_next;
    logic [31:0] newest_reg, newest_next;
    logic [31:0] phase_time_reg, phase_time_next;
    logic        started_reg, started_next;
    logic [15:0] seq_reg, seq_next;
    logic [CW-1:0] total_reg, total_next;
    logic [CW-1:0] done_reg, done_next;
    logic [CW-1:0] origin_reg, origin_next;
    logic [31:0] age_reg, age_next;
    logic [31:0] lpt_reg, lpt_next;
    logic        armed_reg, armed_next;
    logic [CW-1:0] log_reg, log_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [1:0]  k_reg, k_next;

    shld_pkg::result_t res_reg, res_next;
    shld_pkg::result_t out_reg, out_next;
    logic        m_tvalid_reg, m_tvalid_next;

    logic        ram_en, ram_we;
    logic [PW-1:0] ram_addr;
    logic [47:0] ram_rdata;

    logic        accept;
    logic        cfg_fire;
    logic        cfg_change;
    logic [31:0] elapsed;
    logic        due, resync, commit, send;
    logic [PW-1:0] wp_inc;
    logic [PW-1:0] rd_inc;
    logic [PW:0]   addr_sum;
    logic [CW-1:0] remaining, n_sel, sum_done;
    logic [CW+OW-1:0] held_wide, total_wide;

    assign accept     = s_tvalid && s_tready;
    assign cfg_ready  = 1'b1;
    assign cfg_fire   = cfg_valid && cfg_ready;
    assign cfg_change = cfg_fire && (cfg_data != 32'd0) && (cfg_data != interval_reg);
    assign s_tready   = (state_reg == shld_pkg::ST_IDLE);

    assign elapsed  = now_reg - phase_time_reg;
    assign due      = {1'b0, elapsed} >= {1'b0, interval_reg};
    assign resync   = {1'b0, elapsed} >= interval2_reg;
    assign wp_inc   = (wp_reg == PW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rd_inc   = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
    assign addr_sum = {1'b0, oldest_reg} + {1'b0, log_reg[PW-1:0]};
    assign remaining = total_reg - done_reg;

    always_comb begin
        state_next      = state_reg;
        phase_next      = phase_reg;
        interval_next   = interval_reg;
        interval2_next  = interval2_reg;
        wp_next         = wp_reg;
        oldest_next     = oldest_reg;
        held_next       = held_reg;
        newest_next     = newest_reg;
        phase_time_next = phase_time_reg;
        started_next    = started_reg;
        seq_next        = seq_reg;
        total_next      = total_reg;
        done_next       = done_reg;
        origin_next     = origin_reg;
        age_next        = age_reg;
        lpt_next        = lpt_reg;
        armed_next      = armed_reg;
        log_next        = log_reg;
        rd_ptr_next     = rd_ptr_reg;
        k_next          = k_reg;
        res_next        = res_reg;
        out_next        = out_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        ram_en          = 1'b0;
        ram_we          = 1'b0;
        ram_addr        = rd_ptr_reg;
        commit          = 1'b0;
        send            = 1'b0;
        n_sel           = held_reg;
        sum_done        = done_reg;
        held_wide       = '0;
        total_wide      = '0;

        case (state_reg)
            shld_pkg::ST_IDLE: begin
                if (accept) begin
                    state_next = shld_pkg::ST_EXEC;
                end
            end
            shld_pkg::ST_EXEC: begin
                res_next   = '0;
                state_next = shld_pkg::ST_DONE;
                case (mode_reg)
                    shld_pkg::MODE_TICK: begin
                        if (!started_reg) begin
                            if (rvalid_reg) begin
                                started_next    = 1'b1;
                                phase_time_next = now_reg;
                                commit          = 1'b1;
                            end
                        end else if (due) begin
                            phase_time_next = resync ? now_reg : phase_time_reg + interval_reg;
                            commit          = rvalid_reg;
                        end
                        if (commit) begin
                            ram_en      = 1'b1;
                            ram_we      = 1'b1;
                            ram_addr    = wp_reg;
                            wp_next     = wp_inc;
                            newest_next = now_reg;
                            if (held_reg < CW'(DEPTH)) begin
                                held_next = held_reg + 1'b1;
                            end else begin
                                oldest_next = wp_inc;
                            end
                        end
                        res_next.sample_logged = commit;
                        send = (phase_reg != shld_pkg::PH_IDLE) &&
                               (!armed_reg || ((now_reg - lpt_reg) >= 32'(PACKET_GAP_MS)));
                        if (send) begin
                            lpt_next   = now_reg;
                            armed_next = 1'b1;
                            if (phase_reg == shld_pkg::PH_HEADER) begin
                                total_wide                = {{OW{1'b0}}, total_reg};
                                res_next.packet_kind      = shld_pkg::KIND_HEADER;
                                res_next.age_ms           = age_reg;
                                res_next.download_count   = total_wide[OW-1:0];
                                seq_next                  = 16'd1;
                                if (total_reg == '0) begin
                                    phase_next           = shld_pkg::PH_IDLE;
                                    res_next.last_packet = 1'b1;
                                end else begin
                                    phase_next = shld_pkg::PH_DATA;
                                end
                            end else begin
                                res_next.packet_kind  = shld_pkg::KIND_DATA;
                                res_next.sequence_res = seq_reg;
                                seq_next              = seq_reg + 16'd1;
                                k_next   = (remaining >= CW'(2)) ? 2'd2 : remaining[1:0];
                                sum_done = done_reg + CW'(k_next);
                                done_next = sum_done;
                                log_next  = origin_reg + done_reg;
                                res_next.samples_in_packet = k_next;
                                if (sum_done >= total_reg) begin
                                    phase_next           = shld_pkg::PH_IDLE;
                                    res_next.last_packet = 1'b1;
                                end
                                if (k_next != 2'd0) begin
                                    state_next = shld_pkg::ST_ADDR;
                                end
                            end
                        end
                    end
                    shld_pkg::MODE_SUB: begin
                        if ((req_reg != 32'd0) && (req_reg < 32'(held_reg))) begin
                            n_sel = CW'(req_reg);
                        end
                        total_next  = n_sel;
                        done_next   = '0;
                        seq_next    = 16'd0;
                        origin_next = held_reg - n_sel;
                        age_next    = (held_reg != '0) ? now_reg - newest_reg : 32'd0;
                        phase_next  = shld_pkg::PH_HEADER;
                        lpt_next    = 32'd0;
                        armed_next  = 1'b0;
                    end
                    shld_pkg::MODE_UNSUB: begin
                        phase_next = shld_pkg::PH_IDLE;
                    end
                    default: begin
                    end
                endcase
                held_wide             = {{OW{1'b0}}, held_next};
                res_next.stored_count = held_wide[OW-1:0];
            end
            shld_pkg::ST_ADDR: begin
                rd_ptr_next = (addr_sum >= (PW + 1)'(DEPTH)) ?
                              PW'(addr_sum - (PW + 1)'(DEPTH)) : addr_sum[PW-1:0];
                state_next  = shld_pkg::ST_RD0;
            end
            shld_pkg::ST_RD0: begin
                ram_en      = 1'b1;
                rd_ptr_next = rd_inc;
                state_next  = shld_pkg::ST_RD1;
            end
            shld_pkg::ST_RD1: begin
                ram_en                = 1'b1;
                res_next.first_sample = {16'd0, ram_rdata};
                state_next            = shld_pkg::ST_RD2;
            end
            shld_pkg::ST_RD2: begin
                res_next.second_sample = (k_reg == 2'd2) ? {16'd0, ram_rdata} : 64'd0;
                state_next             = shld_pkg::ST_DONE;
            end
            shld_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    out_next      = res_reg;
                    m_tvalid_next = 1'b1;
                    state_next    = shld_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = shld_pkg::ST_IDLE;
            end
        endcase

        if (cfg_change) begin
            interval_next   = cfg_data;
            interval2_next  = {cfg_data, 1'b0};
            wp_next         = '0;
            oldest_next     = '0;
            held_next       = '0;
            newest_next     = 32'd0;
            phase_time_next = 32'd0;
            started_next    = 1'b0;
            phase_next      = shld_pkg::PH_IDLE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= shld_pkg::ST_IDLE;
            phase_reg      <= shld_pkg::PH_IDLE;
            interval_reg   <= shld_pkg::DEFAULT_INTERVAL_MS;
            interval2_reg  <= {shld_pkg::DEFAULT_INTERVAL_MS, 1'b0};
            wp_reg         <= '0;
            oldest_reg     <= '0;
            held_reg       <= '0;
            newest_reg     <= 32'd0;
            phase_time_reg <= 32'd0;
            started_reg    <= 1'b0;
            seq_reg        <= 16'd0;
            total_reg      <= '0;
            done_reg       <= '0;
            origin_reg     <= '0;
            age_reg        <= 32'd0;
            lpt_reg        <= 32'd0;
            armed_reg      <= 1'b0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            state_reg      <= state_next;
            phase_reg      <= phase_next;
            interval_reg   <= interval_next;
            interval2_reg  <= interval2_next;
            wp_reg         <= wp_next;
            oldest_reg     <= oldest_next;
            held_reg       <= held_next;
            newest_reg     <= newest_next;
            phase_time_reg <= phase_time_next;
            started_reg    <= started_next;
            seq_reg        <= seq_next;
            total_reg      <= total_next;
            done_reg       <= done_next;
            origin_reg     <= origin_next;
            age_reg        <= age_next;
            lpt_reg        <= lpt_next;
            armed_reg      <= armed_next;
            m_tvalid_reg   <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        log_reg    <= log_next;
        rd_ptr_reg <= rd_ptr_next;
        k_reg      <= k_next;
        res_reg    <= res_next;
        out_reg    <= out_next;
        if (accept) begin
            mode_reg   <= s_tuser;
            now_reg    <= s_tdata[31:0];
            rvalid_reg <= s_tdata[32];
            smp_in_reg <= s_tdata[80:33];
            req_reg    <= s_tdata[112:81];
        end
    end

    shld_ring #(
        .DEPTH (DEPTH),
        .WIDTH (shld_pkg::SAMPLE_W)
    ) u_ring (
        .aclk  (aclk),
        .en    (ram_en),
        .we    (ram_we),
        .addr  (ram_addr),
        .wdata (smp_in_reg),
        .rdata (ram_rdata)
    );

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_reg.packet_kind;
    assign m_tlast  = out_reg.last_packet;
    assign m_tdata  = {3'd0,
                       out_reg.sample_logged,
                       out_reg.stored_count,
                       out_reg.samples_in_packet,
                       out_reg.second_sample,
                       out_reg.first_sample,
                       out_reg.download_count,
                       out_reg.age_ms,
                       out_reg.sequence_res};

endmodule
